/* hw/rtl/kos_pkg.sv */
// ----------------------------------------------------------------------------
// kos_pkg
// Shared types and codes for the k-th order statistic counter tree: request
// and response beat layouts, operation codes and status codes.
// ----------------------------------------------------------------------------
package kos_pkg;

   // fixed field widths of the request and response beats
   localparam int TARGET_W  = 32;
   localparam int DELTA_W   = 32;
   localparam int KEY_OUT_W = 16;
   localparam int LEAF_W    = 32;   // a leaf count fits in 0 .. 2^32-1

   typedef enum logic {
      OP_TAKE = 1'b0,
      OP_ADD  = 1'b1
   } op_type;

   typedef enum logic [1:0] {
      STS_TAKE_OK  = 2'd0,
      STS_ADD_OK   = 2'd1,
      STS_RANK_BAD = 2'd2,
      STS_ADD_BAD  = 2'd3
   } status_type;

   typedef struct packed {
      op_type                      op;
      logic [TARGET_W-1:0]         target_value;
      logic signed [DELTA_W-1:0]   delta;
   } req_payload_type;

   typedef struct packed {
      logic [KEY_OUT_W-1:0] found_key;
      status_type           status;
   } rsp_payload_type;

endpackage

/* hw/rtl/kos_stream_if.sv */
// ----------------------------------------------------------------------------
// kos_stream_if
// Valid/ready stream channel; a beat moves when valid and ready are both high.
// ----------------------------------------------------------------------------
interface kos_stream_if #(
   parameter type payload_type = logic
);

   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);

endinterface

/* hw/rtl/kos_ram.sv */
// ----------------------------------------------------------------------------
// kos_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module kos_ram #(
   parameter int WIDTH = 48,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* hw/rtl/kth_order_statistic_counter_tree.sv */
// Add: one read and one write of the tree RAM per level, leaf to root.
// Take: one RAM read per level, root to leaf, with the decrement written on
//   the way down. A bad key or a zero rank is answered straight from idle;
//   a rank above the total or a leaf count out of range is answered after
//   the first RAM read.
// One item at a time; the tree RAM's single read port sets the pace.
// After reset a clearing pass writes zero to all 2^(KEY_BITS+1) nodes, one per
//   cycle, before the first request beat is accepted.
// ----------------------------------------------------------------------------
// kth_order_statistic_counter_tree
// Per-key occurrence counts held as a heap-ordered binary sum tree in RAM.
// Add changes one leaf and its ancestors; take descends to the key at a rank
// and removes one occurrence of it.
// ----------------------------------------------------------------------------
module kth_order_statistic_counter_tree
   import kos_pkg::*;
#(
   parameter int KEY_BITS = 16
) (
   input  logic         clock,
   input  logic         reset,
   kos_stream_if.sink   req_ch,
   kos_stream_if.source rsp_ch
);

   localparam int NODE_W = KEY_BITS + 1;          // node index / RAM address
   localparam int SUM_W  = KEY_BITS + LEAF_W;     // widest inner sum
   localparam int DEPTH  = 2 ** NODE_W;

   typedef enum logic [9:0] {
      STATE_CLEAR   = 10'b00_0000_0001,
      STATE_IDLE    = 10'b00_0000_0010,
      STATE_ADD_CHK = 10'b00_0000_0100,
      STATE_UP_RD   = 10'b00_0000_1000,
      STATE_UP_WR   = 10'b00_0001_0000,
      STATE_TK_CHK  = 10'b00_0010_0000,
      STATE_DN_RD   = 10'b00_0100_0000,
      STATE_DN_WR   = 10'b00_1000_0000,
      STATE_RESP    = 10'b01_0000_0000,
      STATE_SPARE   = 10'b10_0000_0000
   } state_type;

   state_type               state_ff, state_in;
   logic [NODE_W-1:0]       clr_ff, clr_in;
   logic [NODE_W-1:0]       node_ff, node_in;
   logic [TARGET_W-1:0]     rank_ff, rank_in;
   logic [SUM_W-1:0]        parent_ff, parent_in;
   logic [SUM_W-1:0]        diff_ff, diff_in;
   logic [KEY_OUT_W-1:0]    res_key_ff, res_key_in;
   status_type              res_status_ff, res_status_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   rsp_payload_type         rsp_data_ff, rsp_data_in;

   // tree RAM port signals
   logic                    wr_en;
   logic [NODE_W-1:0]       wr_addr;
   logic [SUM_W-1:0]        wr_data;
   logic                    rd_en;
   logic [NODE_W-1:0]       rd_addr;
   logic [SUM_W-1:0]        rd_data;

   // datapath helpers
   logic                    req_beat;
   logic                    out_free;
   logic [SUM_W-1:0]        req_diff;
   logic [LEAF_W+1:0]       leaf_new;
   logic                    leaf_bad;
   logic [SUM_W-1:0]        rank_ext;
   logic                    go_left;
   logic [NODE_W-1:0]       left_node;
   logic [SUM_W-1:0]        left_dec;
   logic [SUM_W-1:0]        right_dec;
   logic [SUM_W-1:0]        right_sum;

   kos_ram #(
      .WIDTH (SUM_W),
      .DEPTH (DEPTH)
   ) u_tree_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign req_ch.ready = (state_ff == STATE_IDLE);
   assign req_beat     = req_ch.valid && req_ch.ready;
   assign out_free     = !rsp_valid_ff || rsp_ch.ready;

   assign rsp_ch.valid   = rsp_valid_ff;
   assign rsp_ch.payload = rsp_data_ff;

   // sign-extended delta, added modulo 2^SUM_W along the path
   assign req_diff = {{(SUM_W-DELTA_W){req_ch.payload.delta[DELTA_W-1]}},
                      req_ch.payload.delta};

   // leaf range check: old count plus signed delta in 34-bit two's complement
   assign leaf_new = {2'b00, rd_data[LEAF_W-1:0]}
                   + {diff_ff[LEAF_W-1], diff_ff[LEAF_W-1], diff_ff[LEAF_W-1:0]};
   assign leaf_bad = leaf_new[LEAF_W+1] | leaf_new[LEAF_W];

   // descent step: left child read back; right child sum is parent - left
   assign rank_ext  = {{(SUM_W-TARGET_W){1'b0}}, rank_ff};
   assign go_left   = (rd_data >= rank_ext);
   assign left_node = {node_ff[KEY_BITS-1:0], 1'b0};
   assign left_dec  = rd_data - SUM_W'(1);
   assign right_dec = parent_ff + ~rd_data;       // parent - left - 1
   assign right_sum = parent_ff - rd_data;

   // sequencer
   always_comb begin
      state_in      = state_ff;
      clr_in        = clr_ff;
      node_in       = node_ff;
      rank_in       = rank_ff;
      parent_in     = parent_ff;
      diff_in       = diff_ff;
      res_key_in    = res_key_ff;
      res_status_in = res_status_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ch.ready;
      rsp_data_in   = rsp_data_ff;
      wr_en         = 1'b0;
      wr_addr       = node_ff;
      wr_data       = rd_data + diff_ff;
      rd_en         = 1'b0;
      rd_addr       = node_ff;

      unique case (state_ff)
         STATE_CLEAR: begin
            wr_en   = 1'b1;
            wr_addr = clr_ff;
            wr_data = '0;
            clr_in  = clr_ff + NODE_W'(1);
            if (&clr_ff) begin
               state_in = STATE_IDLE;
            end
         end

         STATE_IDLE: begin
            res_key_in = '0;
            rank_in    = req_ch.payload.target_value;
            diff_in    = req_diff;
            if (req_beat) begin
               if (req_ch.payload.op == OP_ADD) begin
                  if (req_ch.payload.target_value[TARGET_W-1:KEY_BITS] != '0) begin
                     res_status_in = STS_ADD_BAD;
                     state_in      = STATE_RESP;
                  end else begin
                     node_in  = {1'b1, req_ch.payload.target_value[KEY_BITS-1:0]};
                     rd_en    = 1'b1;
                     rd_addr  = {1'b1, req_ch.payload.target_value[KEY_BITS-1:0]};
                     state_in = STATE_ADD_CHK;
                  end
               end else begin
                  if (req_ch.payload.target_value == '0) begin
                     res_status_in = STS_RANK_BAD;
                     state_in      = STATE_RESP;
                  end else begin
                     node_in  = NODE_W'(1);
                     rd_en    = 1'b1;
                     rd_addr  = NODE_W'(1);
                     state_in = STATE_TK_CHK;
                  end
               end
            end
         end

         // leaf count is back: reject or write it and start the climb
         STATE_ADD_CHK: begin
            if (leaf_bad) begin
               res_status_in = STS_ADD_BAD;
               state_in      = STATE_RESP;
            end else begin
               wr_en         = 1'b1;
               res_status_in = STS_ADD_OK;
               node_in       = node_ff >> 1;
               state_in      = STATE_UP_RD;
            end
         end

         STATE_UP_RD: begin
            rd_en    = 1'b1;
            state_in = STATE_UP_WR;
         end

         STATE_UP_WR: begin
            wr_en = 1'b1;
            if (node_ff == NODE_W'(1)) begin
               state_in = STATE_RESP;
            end else begin
               node_in  = node_ff >> 1;
               state_in = STATE_UP_RD;
            end
         end

         // root sum is back: range check, then decrement the root
         STATE_TK_CHK: begin
            if (rank_ext > rd_data) begin
               res_status_in = STS_RANK_BAD;
               state_in      = STATE_RESP;
            end else begin
               wr_en     = 1'b1;
               wr_data   = rd_data - SUM_W'(1);
               parent_in = rd_data;
               state_in  = STATE_DN_RD;
            end
         end

         STATE_DN_RD: begin
            rd_en    = 1'b1;
            rd_addr  = left_node;
            state_in = STATE_DN_WR;
         end

         // pick a child, write its decremented sum
         STATE_DN_WR: begin
            wr_en = 1'b1;
            if (go_left) begin
               wr_addr   = left_node;
               wr_data   = left_dec;
               node_in   = left_node;
               parent_in = rd_data;
            end else begin
               wr_addr   = left_node | NODE_W'(1);
               wr_data   = right_dec;
               node_in   = left_node | NODE_W'(1);
               parent_in = right_sum;
               rank_in   = rank_ff - rd_data[TARGET_W-1:0];
            end
            if (node_ff[KEY_BITS-1]) begin
               // the chosen child is a leaf
               res_status_in = STS_TAKE_OK;
               res_key_in    = KEY_OUT_W'({left_node[KEY_BITS-1:1], !go_left});
               state_in      = STATE_RESP;
            end else begin
               state_in = STATE_DN_RD;
            end
         end

         STATE_RESP: begin
            if (out_free) begin
               rsp_valid_in          = 1'b1;
               rsp_data_in.found_key = res_key_ff;
               rsp_data_in.status    = res_status_ff;
               state_in              = STATE_IDLE;
            end
         end

         default: begin
            state_in = STATE_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= STATE_CLEAR;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      node_ff       <= node_in;
      rank_ff       <= rank_in;
      parent_ff     <= parent_in;
      diff_ff       <= diff_in;
      res_key_ff    <= res_key_in;
      res_status_ff <= res_status_in;
      rsp_data_ff   <= rsp_data_in;
   end

   // a taken request beat holds off the next one
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_beat |=> !req_ch.ready)
      else $error("request accepted while an item is in flight");

   // the climb never reaches the unused node zero
   a_climb_node: assert property (@(posedge clock) disable iff (reset)
      (state_ff == STATE_UP_RD || state_ff == STATE_UP_WR) |-> node_ff != '0)
      else $error("climb addressed node zero");

   // descent reads start only from inner nodes
   a_descend_inner: assert property (@(posedge clock) disable iff (reset)
      state_ff == STATE_DN_RD |-> !node_ff[KEY_BITS] && node_ff != '0)
      else $error("descent started from a leaf");

   // tree writes after the clearing pass never touch node zero
   a_write_addr: assert property (@(posedge clock) disable iff (reset)
      (wr_en && state_ff != STATE_CLEAR) |-> wr_addr != '0)
      else $error("tree write to node zero");

   // a pending response is never overwritten
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ch.ready) |=> rsp_valid_ff && $stable(rsp_data_ff))
      else $error("pending response lost");

endmodule
